// ----- src/assert_macros.svh -----
// Assertion macros shared by the hash table modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/cht_pkg.sv -----
// Types and constants of the chained hash table
package cht_pkg;

   localparam int KEY_W     = 31;
   localparam int MOD_BITS  = 8;
   localparam int MOD_STEPS = 4;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_SEARCH = 1'b1;

   localparam logic [1:0] ST_STORED    = 2'd0;
   localparam logic [1:0] ST_FOUND     = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   typedef struct packed {
      logic             func;
      logic [KEY_W-1:0] key;
   } req_payload_type;

   typedef struct packed {
      logic [1:0] status;
      logic [3:0] bucket;
   } rsp_payload_type;

   typedef struct packed {
      logic       load;
      logic       mod_step;
      logic       clr_write;
      logic       ins_write;
      logic       link_write;
      logic       head_sel;
      logic       respond;
      logic [1:0] status;
   } cht_cmd_type;

   typedef struct packed {
      logic is_insert;
      logic full;
      logic chain_valid;
      logic key_match;
      logic link_valid;
      logic clr_last;
   } cht_sts_type;

endpackage

// ----- src/cht_ram.sv -----
// Generic single write port RAM with registered read
module cht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/cht_ctrl.sv -----
// Controller state machine of the chained hash table
`include "assert_macros.svh"
module cht_ctrl
   import cht_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  cht_sts_type sts,
   output cht_cmd_type cmd
);
   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_MOD   = 3'd2;
   localparam logic [2:0] S_HREAD = 3'd3;
   localparam logic [2:0] S_HWAIT = 3'd4;
   localparam logic [2:0] S_LINK  = 3'd5;
   localparam logic [2:0] S_NWAIT = 3'd6;

   localparam int MCW = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

   logic [2:0]     state_ff, state_in;
   logic [MCW-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_write = 1'b1;
            if (sts.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            cmd.mod_step = 1'b1;
            cnt_in       = cnt_ff + MCW'(1);
            if (cnt_ff == MCW'(MOD_STEPS - 1)) begin
               state_in = S_HREAD;
            end
         end
         S_HREAD: begin
            if (sts.is_insert && sts.full) begin
               cmd.respond = 1'b1;
               cmd.status  = ST_FULL;
               state_in    = S_IDLE;
            end else begin
               state_in = S_HWAIT;
            end
         end
         S_HWAIT: begin
            if (sts.is_insert) begin
               cmd.ins_write = 1'b1;
               if (sts.chain_valid) begin
                  state_in = S_LINK;
               end else begin
                  cmd.respond = 1'b1;
                  cmd.status  = ST_STORED;
                  state_in    = S_IDLE;
               end
            end else if (!sts.chain_valid) begin
               cmd.respond = 1'b1;
               cmd.status  = ST_NOT_FOUND;
               state_in    = S_IDLE;
            end else begin
               cmd.head_sel = 1'b1;
               state_in     = S_NWAIT;
            end
         end
         S_LINK: begin
            cmd.link_write = 1'b1;
            cmd.respond    = 1'b1;
            cmd.status     = ST_STORED;
            state_in       = S_IDLE;
         end
         S_NWAIT: begin
            if (sts.key_match) begin
               cmd.respond = 1'b1;
               cmd.status  = ST_FOUND;
               state_in    = S_IDLE;
            end else if (!sts.link_valid) begin
               cmd.respond = 1'b1;
               cmd.status  = ST_NOT_FOUND;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "busy low after accept")
   `ASSERT_NEXT(a_respond_idle, clock, reset, cmd.respond, !busy, "no return to idle after result")
   `ASSERT_IMPLIES(a_walk_search, clock, reset, state_ff == S_NWAIT, !sts.is_insert,
      "chain walk during insert")

endmodule

// ----- src/cht_datapath.sv -----
// Datapath of the chained hash table: modulo unit, node and chain memories
`include "assert_macros.svh"
module cht_datapath
   import cht_pkg::*;
#(
   parameter int NUM_BUCKETS = 10,
   parameter int NUM_NODES   = 64
) (
   input  logic            clock,
   input  logic            reset,
   input  req_payload_type req,
   input  cht_cmd_type     cmd,
   output cht_sts_type     sts,
   output logic            rsp_valid,
   output rsp_payload_type rsp
);
   localparam int BW    = $clog2(NUM_BUCKETS);
   localparam int NW    = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;
   localparam int UW    = $clog2(NUM_NODES + 1);
   localparam int CHW   = 1 + 2 * NW;
   localparam int PAD_W = MOD_STEPS * MOD_BITS;
   localparam logic [BW:0] MOD_N = (BW + 1)'(NUM_BUCKETS);

   logic             func_ff;
   logic [KEY_W-1:0] key_ff;
   logic [PAD_W-1:0] shift_ff;
   logic [BW-1:0]    rem_ff;
   logic [BW-1:0]    clr_ff;
   logic [UW-1:0]    used_ff;
   logic [NW-1:0]    tail_ff;
   logic [NW-1:0]    node_ff;
   logic             rsp_valid_ff;
   rsp_payload_type  rsp_ff;

   logic [BW-1:0]    rem_in;
   logic [BW:0]      trial;
   logic [NW-1:0]    new_node;

   logic [CHW-1:0]   chain_rd, chain_wr_data;
   logic [BW-1:0]    chain_wr_addr;
   logic [NW-1:0]    chain_head, chain_tail;
   logic [KEY_W-1:0] key_rd;
   logic [NW:0]      link_rd, link_wr_data;
   logic [NW-1:0]    link_wr_addr, node_rd_addr;

   always_comb begin
      rem_in = rem_ff;
      trial  = '0;
      for (int i = 0; i < MOD_BITS; i++) begin
         trial = {rem_in, shift_ff[PAD_W-1-i]};
         if (trial >= MOD_N) begin
            trial = trial - MOD_N;
         end
         rem_in = trial[BW-1:0];
      end
   end

   assign new_node   = used_ff[NW-1:0];
   assign chain_head = chain_rd[2*NW-1:NW];
   assign chain_tail = chain_rd[NW-1:0];

   always_comb begin
      if (cmd.clr_write) begin
         chain_wr_addr = clr_ff;
         chain_wr_data = '0;
      end else begin
         chain_wr_addr = rem_ff;
         chain_wr_data = chain_rd[CHW-1] ? {1'b1, chain_head, new_node}
                                         : {1'b1, new_node, new_node};
      end
   end

   assign link_wr_addr = cmd.link_write ? tail_ff : new_node;
   assign link_wr_data = cmd.link_write ? {1'b1, node_ff} : '0;
   assign node_rd_addr = cmd.head_sel ? chain_head : link_rd[NW-1:0];

   cht_ram #(.WIDTH(CHW), .DEPTH(NUM_BUCKETS)) u_chain_ram (
      .clock   (clock),
      .wr_en   (cmd.clr_write | cmd.ins_write),
      .wr_addr (chain_wr_addr),
      .wr_data (chain_wr_data),
      .rd_addr (rem_ff),
      .rd_data (chain_rd)
   );

   cht_ram #(.WIDTH(KEY_W), .DEPTH(NUM_NODES)) u_key_ram (
      .clock   (clock),
      .wr_en   (cmd.ins_write),
      .wr_addr (new_node),
      .wr_data (key_ff),
      .rd_addr (node_rd_addr),
      .rd_data (key_rd)
   );

   cht_ram #(.WIDTH(NW + 1), .DEPTH(NUM_NODES)) u_link_ram (
      .clock   (clock),
      .wr_en   (cmd.ins_write | cmd.link_write),
      .wr_addr (link_wr_addr),
      .wr_data (link_wr_data),
      .rd_addr (node_rd_addr),
      .rd_data (link_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clr_write) begin
            clr_ff <= clr_ff + BW'(1);
         end
         if (cmd.ins_write) begin
            used_ff <= used_ff + UW'(1);
         end
         rsp_valid_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= req.func;
         key_ff   <= req.key;
         shift_ff <= PAD_W'(req.key);
         rem_ff   <= '0;
      end else if (cmd.mod_step) begin
         shift_ff <= shift_ff << MOD_BITS;
         rem_ff   <= rem_in;
      end
      if (cmd.ins_write) begin
         tail_ff <= chain_tail;
         node_ff <= new_node;
      end
      if (cmd.respond) begin
         rsp_ff.status <= cmd.status;
         rsp_ff.bucket <= 4'(rem_ff);
      end
   end

   assign sts.is_insert   = (func_ff == FUNC_INSERT);
   assign sts.full        = (used_ff == UW'(NUM_NODES));
   assign sts.chain_valid = chain_rd[CHW-1];
   assign sts.key_match   = (key_rd == key_ff);
   assign sts.link_valid  = link_rd[NW];
   assign sts.clr_last    = (clr_ff == BW'(NUM_BUCKETS - 1));

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   `ASSERT_IMPLIES(a_no_write_full, clock, reset, cmd.ins_write, !sts.full,
      "node written with pool used up")
   `ASSERT_IMPLIES(a_used_bound, clock, reset, 1'b1, used_ff <= UW'(NUM_NODES),
      "node count beyond pool")
   `ASSERT_NEXT(a_strobe, clock, reset, cmd.respond, rsp_valid_ff, "result strobe missing")

endmodule

// ----- src/chained_hash_table.sv -----
// Top level of the chained hash table with modulo hashing
//
//   channel   ports                      transfer
//   request   start, busy, req_data      start high while busy low
//   result    rsp_valid, rsp_data        rsp_valid high, one cycle
//
// Bucket = key mod NUM_BUCKETS, computed 8 key bits a cycle.
// Then the bucket's chain entry is read: a full table refuses an insert,
// an insert writes a new node and links it to the chain tail when the
// chain already has one, and a search walks the chain, one node per node
// memory read. After reset busy stays high while the chain memory is
// swept clear.
// The result receiver cannot stall; busy drops as the result is shown.
module chained_hash_table
   import cht_pkg::*;
#(
   parameter int NUM_BUCKETS = 10,
   parameter int NUM_NODES   = 64
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   output rsp_payload_type rsp_data
);
   cht_cmd_type cmd;
   cht_sts_type sts;

   cht_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   cht_datapath #(
      .NUM_BUCKETS (NUM_BUCKETS),
      .NUM_NODES   (NUM_NODES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req       (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_data)
   );

endmodule
